[src/assert_macros.svh]
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

[src/idp_pkg.sv]
package idp_pkg;

	localparam logic [15:0] DASH_CODE = 16'h002D;
	localparam logic [15:0] ZERO_CODE = 16'h0030;
	localparam logic [15:0] NINE_CODE = 16'h0039;

	localparam logic [3:0] DATE_LEN  = 4'd10;
	localparam logic [3:0] LAST_POS  = 4'd9;
	localparam logic [3:0] POS_SAT   = 4'd11;
	localparam logic [3:0] DASH_POS0 = 4'd4;
	localparam logic [3:0] DASH_POS1 = 4'd7;

	// x / 100 == (x * RECIP_100) >> RECIP_SHIFT for x below 10000
	localparam int unsigned RECIP_100   = 5243;
	localparam int unsigned RECIP_SHIFT = 19;
	localparam int unsigned PROD_W      = 27;

	localparam logic [21:0] DAYS_PER_YEAR = 22'd365;
	localparam logic [4:0]  LEAP_FEB_LEN  = 5'd29;

	// One parsed text, handed from the character parser to the date unit.
	typedef struct packed {
		logic        fmt_ok;
		logic [13:0] year;
		logic [6:0]  month;
		logic [6:0]  day;
	} idp_rec_t;

	function automatic logic [8:0] days_before_month(input logic [3:0] m);
		logic [8:0] r;
		case (m)
			4'd1:    r = 9'd0;
			4'd2:    r = 9'd31;
			4'd3:    r = 9'd59;
			4'd4:    r = 9'd90;
			4'd5:    r = 9'd120;
			4'd6:    r = 9'd151;
			4'd7:    r = 9'd181;
			4'd8:    r = 9'd212;
			4'd9:    r = 9'd243;
			4'd10:   r = 9'd273;
			4'd11:   r = 9'd304;
			4'd12:   r = 9'd334;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

	function automatic logic [4:0] month_length(input logic [3:0] m);
		logic [4:0] r;
		case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                     r = 5'd30;
			4'd2:                                        r = 5'd28;
			default:                                     r = 5'd0;
		endcase
		return r;
	endfunction

endpackage

[src/idp_front.sv]
module idp_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic [15:0]      char_code,
	input  logic             is_last,
	output logic             push,
	output idp_pkg::idp_rec_t rec
);
	import idp_pkg::*;

	logic [3:0]  pos_q;
	logic [13:0] year_q;
	logic [6:0]  month_q;
	logic [6:0]  day_q;
	logic        err_q;

	logic [13:0] year_n;
	logic [6:0]  month_n;
	logic [6:0]  day_n;
	logic        err_n;
	logic [3:0]  pos_n;
	logic        is_digit;
	logic [3:0]  digit;

	assign is_digit = (char_code >= ZERO_CODE) && (char_code <= NINE_CODE);
	assign digit    = char_code[3:0];

	always_comb begin
		year_n  = year_q;
		month_n = month_q;
		day_n   = day_q;
		err_n   = err_q;
		if (pos_q >= DATE_LEN) begin
			err_n = 1'b1;
		end else if ((pos_q == DASH_POS0) || (pos_q == DASH_POS1)) begin
			if (char_code != DASH_CODE) begin
				err_n = 1'b1;
			end
		end else if (!is_digit) begin
			err_n = 1'b1;
		end else if (pos_q < DASH_POS0) begin
			year_n = 14'(year_q * 14'd10 + 14'(digit));
		end else if (pos_q < DASH_POS1) begin
			month_n = 7'(month_q * 7'd10 + 7'(digit));
		end else begin
			day_n = 7'(day_q * 7'd10 + 7'(digit));
		end
		pos_n = (pos_q < POS_SAT) ? pos_q + 4'd1 : pos_q;
	end

	assign push       = accept && is_last;
	assign rec.fmt_ok = !err_n && (pos_q == LAST_POS);
	assign rec.year   = year_n;
	assign rec.month  = month_n;
	assign rec.day    = day_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			year_q  <= '0;
			month_q <= '0;
			day_q   <= '0;
			err_q   <= 1'b0;
		end else if (accept) begin
			if (is_last) begin
				pos_q   <= '0;
				year_q  <= '0;
				month_q <= '0;
				day_q   <= '0;
				err_q   <= 1'b0;
			end else begin
				pos_q   <= pos_n;
				year_q  <= year_n;
				month_q <= month_n;
				day_q   <= day_n;
				err_q   <= err_n;
			end
		end
	end

endmodule

[src/idp_queue.sv]
module idp_queue #(
	parameter int unsigned DEPTH = 4,
	parameter int unsigned CNT_W = $clog2(DEPTH + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  idp_pkg::idp_rec_t wr_rec,
	input  logic              pop,
	output idp_pkg::idp_rec_t rd_rec,
	output logic              not_empty,
	output logic              full,
	output logic [CNT_W-1:0]  count
);
	import idp_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	idp_rec_t          mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign rd_rec    = mem_q[rd_ptr_q];
	assign not_empty = (count_q != '0);
	assign full      = (count_q == CNT_W'(DEPTH));
	assign count     = count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[src/idp_back.sv]
module idp_back (
	input  logic              clk,
	input  logic              arst_n,
	input  idp_pkg::idp_rec_t rec,
	input  logic              rec_avail,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              valid_res,
	output logic [13:0]       year_value,
	output logic [3:0]        month_value,
	output logic [4:0]        day_value,
	output logic              leap_year,
	output logic [21:0]       day_number
);
	import idp_pkg::*;

	logic advance;

	// stage 1: constant multiplies on the popped record
	logic [13:0]       prior;
	logic [PROD_W-1:0] prior_prod;
	logic [PROD_W-1:0] year_prod;

	logic        v_s2;
	logic        fmt_ok_s2;
	logic [13:0] year_s2;
	logic [13:0] prior_s2;
	logic [6:0]  month_s2;
	logic [6:0]  day_s2;
	logic [21:0] p365_s2;
	logic [7:0]  pq100_s2;
	logic [7:0]  yq100_s2;

	// stage 2: leap rule, range checks, small day-count terms
	logic [13:0] yrem;
	logic        leap;
	logic [4:0]  dim;
	logic        ok;
	logic [12:0] part;

	logic        v_s3;
	logic        ok_s3;
	logic        leap_s3;
	logic [13:0] year_s3;
	logic [3:0]  month_s3;
	logic [4:0]  day_s3;
	logic [21:0] p365_s3;
	logic [11:0] part_s3;

	logic        out_valid_q;
	logic        valid_res_q;
	logic [13:0] year_q;
	logic [3:0]  month_q;
	logic [4:0]  day_q;
	logic        leap_q;
	logic [21:0] day_num_q;

	assign advance = !out_valid_q || !out_stall;
	assign pop     = advance && rec_avail;

	assign prior      = rec.year - 14'd1;
	assign prior_prod = PROD_W'(prior) * PROD_W'(RECIP_100);
	assign year_prod  = PROD_W'(rec.year) * PROD_W'(RECIP_100);

	assign yrem = year_s2 - 14'(yq100_s2 * 14'd100);
	assign leap = (year_s2[1:0] == 2'b00) && ((yrem != '0) || (yq100_s2[1:0] == 2'b00));
	assign dim  = ((month_s2 == 7'd2) && leap) ? LEAP_FEB_LEN : month_length(month_s2[3:0]);
	assign ok   = fmt_ok_s2 && (year_s2 != '0) && (month_s2 >= 7'd1) && (month_s2 <= 7'd12)
		&& (day_s2 >= 7'd1) && (day_s2 <= 7'(dim));

	// prior/4 - prior/100 + prior/400 + month offset + leap day + day - 1
	assign part = 13'(prior_s2[13:2]) - 13'(pq100_s2) + 13'(pq100_s2[7:2])
		+ 13'(days_before_month(month_s2[3:0]))
		+ 13'(((month_s2 > 7'd2) && leap) ? 1'b1 : 1'b0)
		+ 13'(day_s2) - 13'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			v_s2        <= rec_avail;
			v_s3        <= v_s2;
			out_valid_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			fmt_ok_s2 <= rec.fmt_ok;
			year_s2   <= rec.year;
			prior_s2  <= prior;
			month_s2  <= rec.month;
			day_s2    <= rec.day;
			p365_s2   <= 22'(prior) * DAYS_PER_YEAR;
			pq100_s2  <= 8'(prior_prod >> RECIP_SHIFT);
			yq100_s2  <= 8'(year_prod >> RECIP_SHIFT);

			ok_s3    <= ok;
			leap_s3  <= leap;
			year_s3  <= year_s2;
			month_s3 <= month_s2[3:0];
			day_s3   <= day_s2[4:0];
			p365_s3  <= p365_s2;
			part_s3  <= part[11:0];

			valid_res_q <= ok_s3;
			year_q      <= ok_s3 ? year_s3 : '0;
			month_q     <= ok_s3 ? month_s3 : '0;
			day_q       <= ok_s3 ? day_s3 : '0;
			leap_q      <= ok_s3 && leap_s3;
			day_num_q   <= ok_s3 ? p365_s3 + 22'(part_s3) : '0;
		end
	end

	assign out_valid   = out_valid_q;
	assign valid_res   = valid_res_q;
	assign year_value  = year_q;
	assign month_value = month_q;
	assign day_value   = day_q;
	assign leap_year   = leap_q;
	assign day_number  = day_num_q;

endmodule

[src/iso_date_parse_to_day_number_top.sv]
// Parses an ISO date text "YYYY-MM-DD", one 16-bit character per item with is_last on the
// final character, and returns one result per text: validity, year, month, day, Gregorian
// leap flag and the proleptic day number counted from 0001-01-01 (all zero when invalid).
// One character is taken every cycle while in_stall is low; the character parser keeps
// position and digit accumulators and hands each finished text to a QUEUE_DEPTH-entry
// queue. The date unit behind it is a three-stage pipeline (constant multiplies, checks,
// final add into the output register). in_stall rises only while the queue is full,
// which happens only when out_stall has held the date unit back for a while.
`include "assert_macros.svh"

module iso_date_parse_to_day_number_top #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] char_code,
	input  logic        is_last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        valid_res,
	output logic [13:0] year_value,
	output logic [3:0]  month_value,
	output logic [4:0]  day_value,
	output logic        leap_year,
	output logic [21:0] day_number
);
	import idp_pkg::*;

	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic             accept;
	logic             push;
	logic             pop;
	logic             q_avail;
	logic             q_full;
	logic [CNT_W-1:0] q_count;
	idp_rec_t         front_rec;
	idp_rec_t         back_rec;

	assign in_stall = q_full;
	assign accept   = in_valid && !in_stall;

	idp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.char_code (char_code),
		.is_last   (is_last),
		.push      (push),
		.rec       (front_rec)
	);

	idp_queue #(
		.DEPTH (QUEUE_DEPTH),
		.CNT_W (CNT_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_rec    (front_rec),
		.pop       (pop),
		.rd_rec    (back_rec),
		.not_empty (q_avail),
		.full      (q_full),
		.count     (q_count)
	);

	idp_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.rec         (back_rec),
		.rec_avail   (q_avail),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.valid_res   (valid_res),
		.year_value  (year_value),
		.month_value (month_value),
		.day_value   (day_value),
		.leap_year   (leap_year),
		.day_number  (day_number)
	);

	// input only stalls on a full queue
	`ASSERT_IMPL(a_stall_only_full, clk, arst_n, in_stall, q_count == CNT_W'(QUEUE_DEPTH))
	// a text ending into an empty queue is held there next cycle
	`ASSERT_NEXT(a_push_lands, clk, arst_n, accept && is_last && (q_count == '0),
		q_count == CNT_W'(1))
	// invalid results carry all-zero fields
	`ASSERT_IMPL(a_invalid_zero, clk, arst_n, out_valid && !valid_res,
		(year_value == '0) && (month_value == '0) && (day_value == '0) && !leap_year
		&& (day_number == '0))
	// valid results are real calendar fields
	`ASSERT_IMPL(a_valid_range, clk, arst_n, out_valid && valid_res,
		(year_value != '0) && (month_value != '0) && (month_value <= 4'd12)
		&& (day_value != '0))

endmodule

[tb/tb.sv]
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import idp_pkg::*;

	localparam int unsigned N_CHARS    = 1400;
	localparam int unsigned CALM_CHARS = 150;
	localparam int unsigned WD_LIMIT   = 2000;

	typedef struct packed {
		logic        ok;
		logic [13:0] yr;
		logic [3:0]  mo;
		logic [4:0]  dy;
		logic        leap;
		logic [21:0] dnum;
	} date_res_t;

	typedef struct {
		string       txt;
		logic [15:0] wide;
		bit          typed;
		date_res_t   want;
	} dir_row_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic [15:0] char_code = '0;
	logic        is_last   = 1'b0;
	logic        out_stall = 1'b0;
	logic        in_stall;
	logic        out_valid;
	logic        valid_res;
	logic [13:0] year_value;
	logic [3:0]  month_value;
	logic [4:0]  day_value;
	logic        leap_year;
	logic [21:0] day_number;

	// parser state mirror
	logic [3:0]  txt_pos;
	logic [13:0] acc_year;
	logic [6:0]  acc_month;
	logic [6:0]  acc_day;
	logic        shape_bad;

	date_res_t   pending_dates[$];
	logic [15:0] text_chars[$];
	int unsigned chars_sent  = 0;
	int unsigned mismatches  = 0;
	int unsigned idle_cycles = 0;
	bit          gaps_on     = 1'b1;

	iso_date_parse_to_day_number_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.char_code   (char_code),
		.is_last     (is_last),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.valid_res   (valid_res),
		.year_value  (year_value),
		.month_value (month_value),
		.day_value   (day_value),
		.leap_year   (leap_year),
		.day_number  (day_number)
	);

	always #2 clk = ~clk;

	function automatic bit leap_of(input int unsigned y);
		return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
	endfunction

	function automatic int unsigned month_days(input int unsigned y, input int unsigned m);
		if (m == 2 && leap_of(y))
			return 29;
		case (m)
			1, 3, 5, 7, 8, 10, 12: return 31;
			4, 6, 9, 11:           return 30;
			2:                     return 28;
			default:               return 0;
		endcase
	endfunction

	function automatic int unsigned days_ahead(input int unsigned m);
		case (m)
			2:       return 31;
			3:       return 59;
			4:       return 90;
			5:       return 120;
			6:       return 151;
			7:       return 181;
			8:       return 212;
			9:       return 243;
			10:      return 273;
			11:      return 304;
			12:      return 334;
			default: return 0;
		endcase
	endfunction

	task automatic clear_parse();
		txt_pos   = '0;
		acc_year  = '0;
		acc_month = '0;
		acc_day   = '0;
		shape_bad = 1'b0;
	endtask

	// Advance the mirrored parser by one character; done is set on the closing one.
	task automatic next_date(input logic [15:0] code, input logic fin, output bit done,
		output date_res_t r);
		logic [3:0]  at;
		int unsigned y, m, d, prior;
		bit          good;
		at   = txt_pos;
		done = 1'b0;
		r    = '0;
		if (at >= DATE_LEN) begin
			shape_bad = 1'b1;
		end else if (at == DASH_POS0 || at == DASH_POS1) begin
			if (code != DASH_CODE)
				shape_bad = 1'b1;
		end else if (code < ZERO_CODE || code > NINE_CODE) begin
			shape_bad = 1'b1;
		end else if (at < DASH_POS0) begin
			acc_year = 14'(acc_year * 10 + (code - ZERO_CODE));
		end else if (at < DASH_POS1) begin
			acc_month = 7'(acc_month * 10 + (code - ZERO_CODE));
		end else begin
			acc_day = 7'(acc_day * 10 + (code - ZERO_CODE));
		end
		if (txt_pos < POS_SAT)
			txt_pos = txt_pos + 4'd1;
		if (fin) begin
			y = acc_year;
			m = acc_month;
			d = acc_day;
			good = !shape_bad && at == LAST_POS && y >= 1 && m >= 1 && m <= 12 &&
				d >= 1 && d <= month_days(y, m);
			if (good) begin
				prior  = y - 1;
				r.ok   = 1'b1;
				r.yr   = 14'(y);
				r.mo   = 4'(m);
				r.dy   = 5'(d);
				r.leap = leap_of(y);
				r.dnum = 22'(prior * 365 + prior / 4 - prior / 100 + prior / 400 +
					days_ahead(m) + ((m > 2 && leap_of(y)) ? 1 : 0) + d - 1);
			end
			done = 1'b1;
			clear_parse();
		end
	endtask

	task automatic check_field(input string what, input longint unsigned got,
		input longint unsigned want);
		if (got != want) begin
			$display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
			mismatches++;
		end
	endtask

	task automatic send_char(input logic [15:0] code, input logic fin);
		if (gaps_on && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		in_valid  <= 1'b1;
		char_code <= code;
		is_last   <= fin;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		chars_sent++;
	endtask

	task automatic send_text(input bit typed, input date_res_t want);
		date_res_t r;
		bit        done;
		for (int i = 0; i < text_chars.size(); i++) begin
			send_char(text_chars[i], i == text_chars.size() - 1);
			next_date(text_chars[i], i == text_chars.size() - 1, done, r);
			if (done)
				pending_dates.push_back(typed ? want : r);
		end
	endtask

	// result side: stall bursts while gaps are on
	initial begin
		forever begin
			if (gaps_on && $urandom_range(0, 3) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end
			out_stall <= 1'b0;
			repeat ($urandom_range(1, 30)) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		date_res_t w;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pending_dates.size() == 0) begin
					check_field("result with nothing pending", 1, 0);
				end else begin
					w = pending_dates.pop_front();
					check_field("valid_res", valid_res, w.ok);
					check_field("year_value", year_value, w.yr);
					check_field("month_value", month_value, w.mo);
					check_field("day_value", day_value, w.dy);
					check_field("leap_year", leap_year, w.leap);
					check_field("day_number", day_number, w.dnum);
				end
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WD_LIMIT) begin
				$display("watchdog: no item moved for %0d cycles", WD_LIMIT);
				$display("** iso_date_parse_to_day_number_top: FAILED **");
				$finish;
			end
		end
	end

	initial begin
		dir_row_t    plan[5];
		int unsigned yr_pick[10];
		int unsigned kind, yr, mo, dy, mlen, p, n;
		clear_parse();
		yr_pick = '{0, 1, 4, 100, 400, 1600, 1900, 2000, 2100, 9999};
		plan[0] = '{"0001-01-01", 16'h0000, 1'b1, '{1'b1, 14'd1, 4'd1, 5'd1, 1'b0, 22'd0}};
		plan[1] = '{"9999-12-31", 16'h0000, 1'b1,
			'{1'b1, 14'd9999, 4'd12, 5'd31, 1'b0, 22'd3652058}};
		plan[2] = '{"", 16'hFFFF, 1'b1, '0};
		plan[3] = '{"", 16'h0000, 1'b1, '0};
		plan[4] = '{"00-", 16'h0000, 1'b0, '0};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			text_chars.delete();
			if (plan[i].txt.len() == 0)
				text_chars.push_back(plan[i].wide);
			for (int k = 0; k < plan[i].txt.len(); k++)
				text_chars.push_back({8'h00, plan[i].txt[k]});
			send_text(plan[i].typed, plan[i].want);
		end

		while (chars_sent < N_CHARS) begin
			gaps_on = (chars_sent + CALM_CHARS < N_CHARS);
			text_chars.delete();
			kind = $urandom_range(0, 99);
			if (kind < 90) begin
				yr = ($urandom_range(0, 9) == 0) ? yr_pick[$urandom_range(0, 9)] :
					$urandom_range(0, 9999);
				mo = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(1, 12);
				mlen = month_days(yr, mo);
				case ($urandom_range(0, 7))
					0:       dy = $urandom_range(0, 99);
					1:       dy = mlen + 1;
					2:       dy = mlen;
					3:       dy = 1;
					default: dy = $urandom_range(1, (mlen > 0) ? mlen : 31);
				endcase
				text_chars.push_back(ZERO_CODE + 16'(yr / 1000));
				text_chars.push_back(ZERO_CODE + 16'(yr / 100 % 10));
				text_chars.push_back(ZERO_CODE + 16'(yr / 10 % 10));
				text_chars.push_back(ZERO_CODE + 16'(yr % 10));
				text_chars.push_back(DASH_CODE);
				text_chars.push_back(ZERO_CODE + 16'(mo / 10));
				text_chars.push_back(ZERO_CODE + 16'(mo % 10));
				text_chars.push_back(DASH_CODE);
				text_chars.push_back(ZERO_CODE + 16'(dy / 10));
				text_chars.push_back(ZERO_CODE + 16'(dy % 10));
				// broken variants of a good shape
				if (kind >= 75) begin
					p = $urandom_range(0, 9);
					case ($urandom_range(0, 3))
						0: text_chars[p] = 16'($urandom_range(0, 65535));
						1: begin
							if (p == 4 || p == 7)
								text_chars[p] = ZERO_CODE + 16'($urandom_range(0, 9));
							else if ($urandom_range(0, 1) == 1)
								text_chars[p] = DASH_CODE;
							else
								text_chars[p] = ($urandom_range(0, 1) == 1) ?
									ZERO_CODE - 16'd1 : NINE_CODE + 16'd1;
						end
						2: begin
							n = $urandom_range(1, 9);
							text_chars = text_chars[0:n-1];
						end
						default: begin
							repeat ($urandom_range(1, 6))
								text_chars.push_back(($urandom_range(0, 1) == 1) ?
									16'($urandom_range(0, 65535)) :
									ZERO_CODE + 16'($urandom_range(0, 9)));
						end
					endcase
				end
			end else begin
				repeat ($urandom_range(1, 16))
					text_chars.push_back(($urandom_range(0, 1) == 1) ?
						16'($urandom_range(0, 65535)) : ZERO_CODE + 16'($urandom_range(0, 9)));
			end
			send_text(1'b0, '0);
		end
		gaps_on = 1'b0;
		in_valid <= 1'b0;

		while (pending_dates.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("** iso_date_parse_to_day_number_top: PASSED **");
		else
			$display("** iso_date_parse_to_day_number_top: FAILED **");
		$finish;
	end

endmodule
